[hw/rtl/kest_pkg.sv]
// Shared types and constants for the keyed event statistics table.
`timescale 1ns / 1ps
`default_nettype none

package kest_pkg;

    localparam int KEY_W   = 16;
    localparam int DUR_W   = 32;
    localparam int COUNT_W = 31;
    localparam int TOTAL_W = 48;
    localparam int IDX_W   = 6;   // slot index and rank, enough for 64 slots
    localparam int OP_W    = 2;

    localparam int IN_TDATA_W   = 48;
    localparam int OUT_FIELDS_W = KEY_W + COUNT_W + TOTAL_W + IDX_W;
    localparam int OUT_TDATA_W  = 104;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    localparam logic [OP_W-1:0] OP_RECORD = 2'd0;
    localparam logic [OP_W-1:0] OP_DUMP   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    // Token that walks down the cell chain, one cell per cycle.
    typedef struct packed {
        logic               vld;
        logic               dump;   // 1: best-entry search, 0: record lookup
        logic               hit;    // record: slot found/claimed; dump: candidate held
        logic               claim;  // record took a free slot
        logic [KEY_W-1:0]   key;
        logic [DUR_W-1:0]   dur;
        logic [COUNT_W-1:0] count;
        logic [TOTAL_W-1:0] total;
        logic [IDX_W-1:0]   idx;
    } t_tok;

    // Broadcast controls from the sequencer to every cell.
    typedef struct packed {
        logic             tbl_clr;
        logic             mark_clr;
        logic             mark_en;
        logic [IDX_W-1:0] mark_idx;
    } t_cell_ctl;

endpackage

`default_nettype wire

[hw/rtl/kest_cell.sv]
// One table slot of the cell chain: stores an entry and updates the passing token.
`timescale 1ns / 1ps
`default_nettype none

module kest_cell #(
    parameter int IDX = 0
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire kest_pkg::t_tok      i_tok,
    input  wire kest_pkg::t_cell_ctl i_ctl,
    output kest_pkg::t_tok           o_tok
);
    import kest_pkg::*;

    logic [KEY_W-1:0]   r_key,   n_key;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [TOTAL_W-1:0] r_total, n_total;
    logic               r_occ,   n_occ;
    logic               r_mark,  n_mark;
    t_tok               r_tok,   n_tok;
    logic [TOTAL_W:0]   w_sum;

    always_comb begin
        n_tok   = i_tok;
        n_key   = r_key;
        n_count = r_count;
        n_total = r_total;
        n_occ   = r_occ;
        n_mark  = r_mark;
        w_sum   = {1'b0, r_total} + (TOTAL_W+1)'(i_tok.dur);

        if (i_tok.vld && !i_tok.dump && !i_tok.hit) begin
            if (r_occ && (r_key == i_tok.key)) begin
                n_count   = (r_count == COUNT_MAX) ? r_count : r_count + 1'b1;
                n_total   = w_sum[TOTAL_W] ? TOTAL_MAX : w_sum[TOTAL_W-1:0];
                n_tok.hit = 1'b1;
            end else if (!r_occ) begin
                // first free slot: slots fill in arrival order
                n_key       = i_tok.key;
                n_count     = COUNT_W'(1);
                n_total     = TOTAL_W'(i_tok.dur);
                n_occ       = 1'b1;
                n_tok.hit   = 1'b1;
                n_tok.claim = 1'b1;
            end
        end

        // strict compare keeps the earlier slot on equal counts
        if (i_tok.vld && i_tok.dump && r_occ && !r_mark &&
            (!i_tok.hit || (r_count > i_tok.count))) begin
            n_tok.hit   = 1'b1;
            n_tok.key   = r_key;
            n_tok.count = r_count;
            n_tok.total = r_total;
            n_tok.idx   = IDX_W'(IDX);
        end

        if (i_ctl.mark_clr) begin
            n_mark = 1'b0;
        end else if (i_ctl.mark_en && (i_ctl.mark_idx == IDX_W'(IDX))) begin
            n_mark = 1'b1;
        end

        if (i_ctl.tbl_clr) begin
            n_occ = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ     <= 1'b0;
            r_mark    <= 1'b0;
            r_tok.vld <= 1'b0;
        end else begin
            r_occ  <= n_occ;
            r_mark <= n_mark;
            r_tok  <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_count <= n_count;
        r_total <= n_total;
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

[hw/rtl/keyed_event_stats_table_top.sv]
// Top level of the keyed event statistics table: cell chain plus sequencer.
`timescale 1ns / 1ps
`default_nettype none

// Per-key event statistics over a chain of CAPACITY cells, one slot per cell.
// The block works on one item at a time. A record item sends a lookup token
// down the chain, one cell per cycle: the first occupied cell with the same key
// adds one to its count and the duration to its total (both saturate), and if
// none matches the first free cell takes the key; a full table drops the key.
// A record occupies the block until its token has left the end of the chain.
// A clear item needs no pass through the chain. A dump runs one search pass
// through the chain per reported entry, picking the unreported entry with the
// highest count (earliest slot on ties); each result must be taken by the
// downstream side before the next pass starts. An empty table dumps one result
// with the empty flag and tlast set and all other fields zero. New items are
// taken only when the block is idle and its output register is free or being
// emptied.
module keyed_event_stats_table_top #(
    parameter int CAPACITY = 32
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // input items
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire  [kest_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // event_key, duration_ns
    input  wire  [kest_pkg::OP_W-1:0]          s_axis_tuser,  // operation
    // dump results
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    output logic [kest_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // entry_key, call_count,
                                                              // total_ns, rank, zero pad
    output logic [0:0]                         m_axis_tuser,  // table_empty
    output logic                               m_axis_tlast   // last_entry
);
    import kest_pkg::*;

    localparam int UW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_OUT
    } t_state;

    t_state             r_state;
    t_tok               r_inj;
    logic [UW-1:0]      r_used;
    logic [IDX_W-1:0]   r_rank;
    logic               r_ovld;
    logic [KEY_W-1:0]   r_o_key;
    logic [COUNT_W-1:0] r_o_count;
    logic [TOTAL_W-1:0] r_o_total;
    logic [IDX_W-1:0]   r_o_rank;
    logic               r_o_empty;
    logic               r_o_last;

    t_tok               w_tok [CAPACITY+1];
    t_tok               w_exit;
    t_tok               w_rec_tok;
    t_tok               w_dump_tok;
    t_cell_ctl          w_ctl;
    logic               w_s_acc;
    logic               w_last;

    assign s_axis_tready = (r_state == S_IDLE) && (!r_ovld || m_axis_tready);
    assign w_s_acc       = s_axis_tvalid && s_axis_tready;

    assign w_tok[0] = r_inj;
    assign w_exit   = w_tok[CAPACITY];

    // the result now leaving the chain is the final one of the dump
    assign w_last = ((IDX_W+1)'(r_rank) + (IDX_W+1)'(1)) == (IDX_W+1)'(r_used);

    always_comb begin
        w_rec_tok       = '0;
        w_rec_tok.vld   = 1'b1;
        w_rec_tok.key   = s_axis_tdata[KEY_W-1:0];
        w_rec_tok.dur   = s_axis_tdata[KEY_W +: DUR_W];
        w_dump_tok      = '0;
        w_dump_tok.vld  = 1'b1;
        w_dump_tok.dump = 1'b1;
    end

    // broadcast controls: act on the edge at which they are raised
    always_comb begin
        w_ctl = '0;
        if (w_s_acc && (s_axis_tuser == OP_CLEAR)) begin
            w_ctl.tbl_clr = 1'b1;
        end
        if ((r_state == S_RUN) && w_exit.vld && w_exit.dump) begin
            if (w_last) begin
                w_ctl.mark_clr = 1'b1;           // dump done: release all marks
            end else begin
                w_ctl.mark_en  = 1'b1;           // hide the winner from later passes
                w_ctl.mark_idx = w_exit.idx;
            end
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        kest_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_tok[g]),
            .i_ctl   (w_ctl),
            .o_tok   (w_tok[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_inj.vld <= 1'b0;
            r_used    <= '0;
            r_ovld    <= 1'b0;
        end else begin
            r_inj.vld <= 1'b0;
            if (r_ovld && m_axis_tready) begin
                r_ovld <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_s_acc) begin
                        unique case (s_axis_tuser)
                            OP_RECORD: begin
                                r_inj   <= w_rec_tok;
                                r_state <= S_RUN;
                            end
                            OP_DUMP: begin
                                if (r_used == '0) begin
                                    // empty table: one flagged result
                                    r_o_key   <= '0;
                                    r_o_count <= '0;
                                    r_o_total <= '0;
                                    r_o_rank  <= '0;
                                    r_o_empty <= 1'b1;
                                    r_o_last  <= 1'b1;
                                    r_ovld    <= 1'b1;
                                end else begin
                                    r_inj   <= w_dump_tok;
                                    r_rank  <= '0;
                                    r_state <= S_RUN;
                                end
                            end
                            OP_CLEAR: begin
                                r_used <= '0;
                            end
                            default: begin
                                // unused code: drop the item
                            end
                        endcase
                    end
                end
                S_RUN: begin
                    if (w_exit.vld) begin
                        if (w_exit.dump) begin
                            r_o_key   <= w_exit.key;
                            r_o_count <= w_exit.count;
                            r_o_total <= w_exit.total;
                            r_o_rank  <= r_rank;
                            r_o_empty <= 1'b0;
                            r_o_last  <= w_last;
                            r_ovld    <= 1'b1;
                            r_state   <= w_last ? S_IDLE : S_OUT;
                        end else begin
                            if (w_exit.claim) begin
                                r_used <= r_used + 1'b1;
                            end
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_OUT: begin
                    // hold until the result is taken, then start the next pass
                    if (m_axis_tready) begin
                        r_rank  <= r_rank + 1'b1;
                        r_inj   <= w_dump_tok;
                        r_state <= S_RUN;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}},
                            r_o_rank, r_o_total, r_o_count, r_o_key};
    assign m_axis_tuser  = r_o_empty;
    assign m_axis_tlast  = r_o_last;

endmodule

`default_nettype wire

[hw/rtl/kest_checker.sv]
// Port-level checks for the keyed event statistics table, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module kest_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              s_axis_tvalid,
    input wire                              s_axis_tready,
    input wire [kest_pkg::OP_W-1:0]         s_axis_tuser,
    input wire                              m_axis_tvalid,
    input wire                              m_axis_tready,
    input wire [kest_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input wire [0:0]                        m_axis_tuser,
    input wire                              m_axis_tlast
);
    import kest_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // no new item while a result waits
    a_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while output stalled");

    // an empty dump is a single all-zero result
    a_empty_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast && (m_axis_tdata == '0))
        else $error("empty result malformed");

    // a result is offered only after a dump was accepted: a clear, record or
    // unused item accepted in the previous cycle never starts output at once
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser != OP_DUMP) |=> !$rose(m_axis_tvalid))
        else $error("result after a non-dump item");

endmodule

bind keyed_event_stats_table_top kest_checker u_kest_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

[bench/keyed_event_stats_table_top_tb.sv]
// Self-checking testbench for the keyed event statistics table.
`timescale 1ns / 1ps

module keyed_event_stats_table_top_tb;
    import kest_pkg::*;

    localparam int SLOTS      = 32;
    localparam int ITEM_GOAL  = 420;
    localparam int LIMIT      = 2_000_000;
    localparam int LONG_HOLD  = 1500;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // one expected dump result, laid out field by field
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
        logic [TOTAL_W-1:0] total;
        logic [IDX_W-1:0]   rank;
        logic               empty;
        logic               last;
    } t_dump_result;

    // Table model plus the queue of dump results still to come.
    class stats_scoreboard;
        logic [KEY_W-1:0]   slot_key   [SLOTS];
        logic [COUNT_W-1:0] slot_count [SLOTS];
        logic [TOTAL_W-1:0] slot_total [SLOTS];
        int                 used;
        int                 errors;
        t_dump_result       awaited_q [$];

        function new();
            used   = 0;
            errors = 0;
        endfunction

        function int pending();
            return awaited_q.size();
        endfunction

        function void note_item(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                logic [DUR_W-1:0] dur);
            case (op)
                OP_RECORD: add_event(key, dur);
                OP_DUMP:   predict_dump();
                OP_CLEAR:  used = 0;
                default:   ;
            endcase
        endfunction

        function void add_event(logic [KEY_W-1:0] key, logic [DUR_W-1:0] dur);
            logic [TOTAL_W:0] sum;
            for (int i = 0; i < used; i++) begin
                if (slot_key[i] == key) begin
                    if (slot_count[i] != COUNT_MAX)
                        slot_count[i] = slot_count[i] + 1'b1;
                    sum = {1'b0, slot_total[i]} + (TOTAL_W+1)'(dur);
                    slot_total[i] = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[TOTAL_W-1:0];
                    return;
                end
            end
            // miss: claim the next free slot, or drop the key when full
            if (used < SLOTS) begin
                slot_key[used]   = key;
                slot_count[used] = COUNT_W'(1);
                slot_total[used] = TOTAL_W'(dur);
                used++;
            end
        endfunction

        // Selection order: highest count first, lowest slot index on ties.
        function void predict_dump();
            bit           taken [SLOTS];
            t_dump_result r;
            int           best;
            if (used == 0) begin
                r       = '0;
                r.empty = 1'b1;
                r.last  = 1'b1;
                awaited_q.push_back(r);
                return;
            end
            foreach (taken[i]) taken[i] = 1'b0;
            for (int n = 0; n < used; n++) begin
                best = -1;
                for (int i = 0; i < used; i++)
                    if (!taken[i] && (best < 0 || slot_count[i] > slot_count[best]))
                        best = i;
                taken[best] = 1'b1;
                r       = '0;
                r.key   = slot_key[best];
                r.count = slot_count[best];
                r.total = slot_total[best];
                r.rank  = n[IDX_W-1:0];
                r.last  = (n == used - 1);
                awaited_q.push_back(r);
            end
        endfunction

        function void compare(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] data, logic empty, logic last);
            t_dump_result e;
            if (awaited_q.size() == 0) begin
                $error("unexpected dump result: tdata=%h empty=%b last=%b", data, empty, last);
                errors++;
                return;
            end
            e = awaited_q.pop_front();
            compare("entry_key",   e.key,   data[KEY_W-1:0]);
            compare("call_count",  e.count, data[KEY_W +: COUNT_W]);
            compare("total_ns",    e.total, data[KEY_W+COUNT_W +: TOTAL_W]);
            compare("rank",        e.rank,  data[KEY_W+COUNT_W+TOTAL_W +: IDX_W]);
            compare("tdata_pad",   0,       data[OUT_TDATA_W-1:OUT_FIELDS_W]);
            compare("table_empty", e.empty, empty);
            compare("last_entry",  e.last,  last);
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // event_key, duration_ns
    logic [OP_W-1:0]        s_axis_tuser;   // operation
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // entry_key, call_count, total_ns, rank, pad
    logic [0:0]             m_axis_tuser;   // table_empty
    logic                   m_axis_tlast;   // last_entry

    stats_scoreboard table_sb;
    bit              rst_done    = 1'b0;
    bit              no_gaps     = 1'b0;   // both sides run without idling
    int              hold_cycles = 0;      // one-shot long stall for the receiver
    int              items_sent  = 0;
    int              cycle_count = 0;

    keyed_event_stats_table_top #(
        .CAPACITY(SLOTS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Offer one item after a random gap; return at the edge that takes it.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                             input logic [DUR_W-1:0] dur);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {dur, key};
        @(posedge i_clk);
        while (s_axis_tready !== 1'b1) @(posedge i_clk);
        table_sb.note_item(op, key, dur);
        items_sent++;
    endtask

    // Hold the input until every awaited dump result has been taken.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (table_sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [DUR_W-1:0] pick_duration();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return $urandom_range(0, 1000);
            default: return $urandom();
        endcase
    endfunction

    // Receiver: random stall before each result, plus the one long hold-off.
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        wait (rst_done);
        @(posedge i_clk);
        forever begin
            if (hold_cycles > 0) begin
                stall       = hold_cycles;
                hold_cycles = 0;
            end else begin
                stall = no_gaps ? 0 : $urandom_range(0, 14);
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (m_axis_tvalid !== 1'b1) @(posedge i_clk);
            table_sb.check_result(m_axis_tdata, m_axis_tuser[0], m_axis_tlast);
        end
    end

    initial begin
        logic [KEY_W-1:0] key_pool [$];
        int               pool_n;
        int               rec_n;
        int               round_idx;
        table_sb      = new();
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_RECORD;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        rst_done = 1'b1;

        // directed: empty dumps, the unused code, key and duration extremes,
        // count ties resolved by arrival, clear of an occupied and an empty table
        send_item(OP_DUMP,   16'h0000, 32'h0000_0000);
        send_item(OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(OP_DUMP,   16'hFFFF, 32'hFFFF_FFFF);
        send_item(OP_RECORD, 16'h0000, 32'h0000_0000);
        send_item(OP_RECORD, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(OP_RECORD, 16'h0000, 32'hFFFF_FFFF);
        send_item(OP_RECORD, 16'h1234, 32'h0000_0005);
        send_item(OP_RECORD, 16'hFFFF, 32'h0000_0001);
        send_item(OP_RECORD, 16'h1234, 32'h0000_0007);
        send_item(OP_RECORD, 16'h00FF, 32'h0000_0000);
        send_item(OP_UNUSED, 16'h0000, 32'h0000_0000);
        send_item(OP_DUMP,   16'h0000, 32'h0000_0000);
        send_item(OP_CLEAR,  16'h0000, 32'h0000_0000);
        send_item(OP_DUMP,   16'h0000, 32'h0000_0000);
        send_item(OP_RECORD, 16'h5555, 32'h0000_0001);
        send_item(OP_RECORD, 16'hAAAA, 32'h0000_0002);
        send_item(OP_RECORD, 16'hAAAA, 32'h0000_0003);
        send_item(OP_DUMP,   16'h0000, 32'h0000_0000);
        send_item(OP_CLEAR,  16'h0000, 32'h0000_0000);
        send_item(OP_CLEAR,  16'h0000, 32'h0000_0000);
        send_item(OP_DUMP,   16'h0000, 32'h0000_0000);

        // random rounds: records over a key pool, then a dump; wide pools
        // overfill the table so new keys get dropped
        round_idx = 0;
        while (items_sent < ITEM_GOAL) begin
            no_gaps = ($urandom_range(0, 4) == 0);
            pool_n  = ($urandom_range(0, 3) == 0) ? $urandom_range(33, 48)
                                                   : $urandom_range(1, 12);
            rec_n   = (pool_n > SLOTS) ? $urandom_range(40, 70) : $urandom_range(3, 25);
            key_pool.delete();
            repeat (pool_n) key_pool.push_back(KEY_W'($urandom()));
            repeat (rec_n) begin
                if (items_sent < ITEM_GOAL) begin
                    case ($urandom_range(0, 39))
                        0, 1:    send_item(OP_UNUSED, KEY_W'($urandom()), $urandom());
                        2:       send_item(OP_DUMP, KEY_W'($urandom()), $urandom());
                        default: send_item(OP_RECORD,
                                           key_pool[$urandom_range(0, pool_n - 1)],
                                           pick_duration());
                    endcase
                end
            end
            // stall the receiver long while dumps and records keep coming
            if (round_idx == 1)
                hold_cycles = LONG_HOLD;
            send_item(OP_DUMP, KEY_W'($urandom()), $urandom());
            if (round_idx == 1 || $urandom_range(0, 5) == 0) begin
                send_item(OP_DUMP, KEY_W'($urandom()), $urandom());
                send_item(OP_RECORD, key_pool[0], pick_duration());
                send_item(OP_DUMP, KEY_W'($urandom()), $urandom());
            end
            if ($urandom_range(0, 1) == 0)
                send_item(OP_CLEAR, KEY_W'($urandom()), $urandom());
            if (round_idx == 0 || $urandom_range(0, 3) == 0)
                wait_drained();
            round_idx++;
        end

        wait_drained();
        repeat (2 * SLOTS + 8) @(posedge i_clk);
        if (table_sb.errors == 0 && table_sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
